FILE: hw/rtl/cli_pkg.sv
// Shared widths, register codes and helpers for the circle/line intersection block.
// Used by every module in hw/rtl; depends on nothing.
package cli_pkg;

   // Port and coordinate widths.
   localparam int CW      = 32;   // Q16.16 coordinate
   localparam int RW      = 31;   // radius
   localparam int LW      = 33;   // circle-local coordinate or line delta
   localparam int CSR_IW  = 2;    // register index width

   // Wide multiplier: magnitudes split into three 23-bit limbs.
   localparam int MUL_W   = 68;
   localparam int PROD_W  = 136;
   localparam int LIMB_W  = 23;
   localparam int NLIMB   = 3;
   localparam int PP_W    = 2 * LIMB_W;
   localparam int ROW_W   = PP_W + LIMB_W * (NLIMB - 1) + 2;
   localparam int MUL_LAT = 5;

   // Intermediate widths.
   localparam int DR_W    = 66;   // dx^2 + dy^2
   localparam int DD_W    = 67;   // cross product
   localparam int RR_W    = 62;   // r^2
   localparam int DL_W    = 132;  // discriminant
   localparam int SQ_IN_W = 128;  // non-negative discriminant
   localparam int SQ_W    = 64;   // floor square root
   localparam int REM_W   = 130;  // square root remainder
   localparam int NUM_W   = 100;  // signed numerator
   localparam int DIVN_W  = 99;   // numerator magnitude
   localparam int QM_W    = 32;   // quotient magnitude
   localparam int Q_W     = 33;   // signed quotient
   localparam int EX_W    = 34;   // point minus start
   localparam int DOT_W   = 68;   // projection dot product
   localparam int SUM_W   = 34;   // point plus center

   // Register indexes.
   localparam logic [CSR_IW-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_RADIUS   = 2'd2;

   // Saturate a widened sum to the signed 32-bit range.
   function automatic logic signed [CW-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(64'sh7FFF_FFFF);
      lo = -SUM_W'(64'sh8000_0000);
      if (v >= hi) begin
         sat32 = {1'b0, {(CW-1){1'b1}}};
      end else if (v <= lo) begin
         sat32 = {1'b1, {(CW-1){1'b0}}};
      end else begin
         sat32 = v[CW-1:0];
      end
   endfunction

endpackage

FILE: hw/rtl/circle_line_intersection.sv
// Circle/line intersection top level: pipeline control, stage registers, output sequencing.
// Uses cli_pkg, cli_mul, cli_sqrt and cli_div.
//
// A line beat enters on start while busy is low, one per cycle. Its first result reaches
// rsp_* through a chain of 126 registers: four limb-product multiplier passes, a
// 64-stage bit-per-stage square root, a 32-stage divider and ten single stages. A line
// that keeps two points sends them on consecutive cycles and holds busy high for the
// first of them, freezing the whole pipeline for that cycle; every other line gives a
// single result beat. Each result beat is on rsp_* for one cycle only, marked by
// rsp_valid, so the receiver must always take it. The user must see that registers are
// written only while the block is empty; the block itself does not enforce this.
module circle_line_intersection (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [cli_pkg::CW-1:0]      req_start_x,
   input  logic signed [cli_pkg::CW-1:0]      req_start_y,
   input  logic signed [cli_pkg::CW-1:0]      req_end_x,
   input  logic signed [cli_pkg::CW-1:0]      req_end_y,
   input  logic                               req_unbounded_line,
   output logic                               rsp_valid,
   output logic signed [cli_pkg::CW-1:0]      rsp_point_x,
   output logic signed [cli_pkg::CW-1:0]      rsp_point_y,
   output logic                               rsp_found,
   output logic                               rsp_last,
   input  logic                               csr_write,
   input  logic [cli_pkg::CSR_IW-1:0]         csr_index,
   input  logic [cli_pkg::CW-1:0]             csr_data
);

   // Line data that travels down the pipeline.
   typedef struct packed {
      logic signed [cli_pkg::LW-1:0] x1;
      logic signed [cli_pkg::LW-1:0] y1;
      logic signed [cli_pkg::LW-1:0] dx;
      logic signed [cli_pkg::LW-1:0] dy;
      logic [cli_pkg::DR_W-1:0]      dr2;
      logic                          unb;
      logic                          hit;
      logic                          two;
   } line_type;

   typedef struct packed {
      logic signed [cli_pkg::NUM_W-1:0] ax;
      logic signed [cli_pkg::NUM_W-1:0] ay;
   } axis_type;

   typedef struct packed {
      line_type line;
      axis_type axis;
   } lax_type;

   typedef struct packed {
      line_type  line;
      logic [3:0] neg;
   } lneg_type;

   typedef struct packed {
      line_type                       line;
      logic [3:0][cli_pkg::Q_W-1:0]   q;
   } lq_type;

   // Configuration registers.
   logic signed [cli_pkg::CW-1:0] cx_ff, cy_ff;
   logic [cli_pkg::RW-1:0]        r_ff;

   logic adv, stall;

   // Stage A.
   line_type                      a_ff, a_in;
   logic signed [cli_pkg::LW-1:0] a_x2_ff, a_y2_ff, a_x2_in, a_y2_in;
   logic                          a_vld_ff;

   // Multiplier pass 1.
   logic signed [cli_pkg::PROD_W-1:0] p_dxdx, p_dydy, p_x1y2, p_x2y1, p_rr;
   line_type                          l1_ff [cli_pkg::MUL_LAT];
   logic [cli_pkg::MUL_LAT-1:0]       l1_vld_ff;

   // Stage B.
   line_type                       b_ff, b_in;
   logic signed [cli_pkg::DD_W-1:0] b_dd_ff, b_dd_in;
   logic [cli_pkg::RR_W-1:0]       b_rr_ff, b_rr_in;
   logic                           b_vld_ff;

   // Multiplier pass 2.
   logic signed [cli_pkg::PROD_W-1:0] p_rrdr, p_dd2, p_ax, p_ay;
   line_type                          l2_ff [cli_pkg::MUL_LAT];
   logic [cli_pkg::MUL_LAT-1:0]       l2_vld_ff;

   // Stage C.
   lax_type                         c_ff, c_in;
   logic [cli_pkg::SQ_IN_W-1:0]     c_rad_ff, c_rad_in;
   logic signed [cli_pkg::DL_W-1:0] delta;
   logic                            c_vld_ff;

   // Square root.
   logic [cli_pkg::SQ_W-1:0] root;
   lax_type                  l3_ff [cli_pkg::SQ_W];
   logic [cli_pkg::SQ_W-1:0] l3_vld_ff;

   // Stage D.
   lax_type                       d_ff;
   logic [cli_pkg::SQ_W-1:0]      d_root_ff;
   logic signed [cli_pkg::LW-1:0] d_sdx_ff, d_ady_ff, d_sdx_in, d_ady_in;
   logic                          d_vld_ff;

   // Multiplier pass 3.
   logic signed [cli_pkg::PROD_W-1:0] p_bx, p_by;
   lax_type                           l4_ff [cli_pkg::MUL_LAT];
   logic [cli_pkg::MUL_LAT-1:0]       l4_vld_ff;

   // Stage E: numerators, order x0, y0, x1, y1.
   line_type                         e_ff;
   logic signed [cli_pkg::NUM_W-1:0] e_n_ff [4];
   logic signed [cli_pkg::NUM_W-1:0] e_n_in [4];
   logic signed [cli_pkg::NUM_W-1:0] bx, by;
   logic                             e_vld_ff;

   // Stage F: magnitudes and signs.
   line_type                         f_ff;
   logic [cli_pkg::DIVN_W-1:0]       f_mag_ff [4];
   logic [cli_pkg::DIVN_W-1:0]       f_mag_in [4];
   logic signed [cli_pkg::NUM_W-1:0] neg_n [4];
   logic [3:0]                       f_neg_ff, f_neg_in;
   logic                             f_vld_ff;

   // Dividers.
   logic [cli_pkg::QM_W-1:0] quo [4];
   lneg_type                 l5_ff [cli_pkg::QM_W];
   logic [cli_pkg::QM_W-1:0] l5_vld_ff;

   // Stage G: signed quotients.
   line_type                      g_ff;
   logic signed [cli_pkg::Q_W-1:0] g_q_ff [4];
   logic signed [cli_pkg::Q_W-1:0] g_q_in [4];
   logic                           g_vld_ff;

   // Stage H: point minus start.
   line_type                        h_ff;
   logic signed [cli_pkg::Q_W-1:0]  h_q_ff [4];
   logic signed [cli_pkg::EX_W-1:0] h_ex_ff [4];
   logic signed [cli_pkg::EX_W-1:0] h_ex_in [4];
   logic                            h_vld_ff;

   // Multiplier pass 4.
   logic signed [cli_pkg::PROD_W-1:0] p_dot [4];
   lq_type                            l6_ff [cli_pkg::MUL_LAT];
   lq_type                            l6_in;
   logic [cli_pkg::MUL_LAT-1:0]       l6_vld_ff;

   // Stage I: dot products and shifted points.
   line_type                         i_ff;
   logic signed [cli_pkg::DOT_W-1:0] i_dot_ff [2];
   logic signed [cli_pkg::DOT_W-1:0] i_dot_in [2];
   logic signed [cli_pkg::SUM_W-1:0] i_sum_ff [4];
   logic signed [cli_pkg::SUM_W-1:0] i_sum_in [4];
   logic                             i_vld_ff;

   // Output stage.
   logic signed [cli_pkg::CW-1:0]    o_pt_ff [4];
   logic signed [cli_pkg::CW-1:0]    o_pt_in [4];
   logic [1:0]                       o_keep_ff, o_keep_in;
   logic [1:0]                       on_seg;
   logic                             o_vld_ff, o_second_ff;

   // A line with two kept points holds everything while its first point is on the output.
   assign stall = o_vld_ff && !o_second_ff && o_keep_ff[0] && o_keep_ff[1];
   assign adv   = !stall;
   assign busy  = stall;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         r_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            cli_pkg::CSR_CENTER_X: cx_ff <= $signed(csr_data);
            cli_pkg::CSR_CENTER_Y: cy_ff <= $signed(csr_data);
            cli_pkg::CSR_RADIUS:   r_ff  <= csr_data[cli_pkg::RW-1:0];
            default: ;
         endcase
      end
   end

   // Valid bits of every stage and delay line up to stage I.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff  <= 1'b0;
         l1_vld_ff <= '0;
         b_vld_ff  <= 1'b0;
         l2_vld_ff <= '0;
         c_vld_ff  <= 1'b0;
         l3_vld_ff <= '0;
         d_vld_ff  <= 1'b0;
         l4_vld_ff <= '0;
         e_vld_ff  <= 1'b0;
         f_vld_ff  <= 1'b0;
         l5_vld_ff <= '0;
         g_vld_ff  <= 1'b0;
         h_vld_ff  <= 1'b0;
         l6_vld_ff <= '0;
         i_vld_ff  <= 1'b0;
      end else if (adv) begin
         a_vld_ff  <= start;
         l1_vld_ff <= {l1_vld_ff[cli_pkg::MUL_LAT-2:0], a_vld_ff};
         b_vld_ff  <= l1_vld_ff[cli_pkg::MUL_LAT-1];
         l2_vld_ff <= {l2_vld_ff[cli_pkg::MUL_LAT-2:0], b_vld_ff};
         c_vld_ff  <= l2_vld_ff[cli_pkg::MUL_LAT-1];
         l3_vld_ff <= {l3_vld_ff[cli_pkg::SQ_W-2:0], c_vld_ff};
         d_vld_ff  <= l3_vld_ff[cli_pkg::SQ_W-1];
         l4_vld_ff <= {l4_vld_ff[cli_pkg::MUL_LAT-2:0], d_vld_ff};
         e_vld_ff  <= l4_vld_ff[cli_pkg::MUL_LAT-1];
         f_vld_ff  <= e_vld_ff;
         l5_vld_ff <= {l5_vld_ff[cli_pkg::QM_W-2:0], f_vld_ff};
         g_vld_ff  <= l5_vld_ff[cli_pkg::QM_W-1];
         h_vld_ff  <= g_vld_ff;
         l6_vld_ff <= {l6_vld_ff[cli_pkg::MUL_LAT-2:0], h_vld_ff};
         i_vld_ff  <= l6_vld_ff[cli_pkg::MUL_LAT-1];
      end
   end

   // Stage A: shift into circle-local coordinates.
   always_comb begin
      a_in.x1  = cli_pkg::LW'(req_start_x) - cli_pkg::LW'(cx_ff);
      a_in.y1  = cli_pkg::LW'(req_start_y) - cli_pkg::LW'(cy_ff);
      a_in.dx  = cli_pkg::LW'(req_end_x) - cli_pkg::LW'(req_start_x);
      a_in.dy  = cli_pkg::LW'(req_end_y) - cli_pkg::LW'(req_start_y);
      a_in.dr2 = '0;
      a_in.unb = req_unbounded_line;
      a_in.hit = 1'b0;
      a_in.two = 1'b0;
      a_x2_in  = cli_pkg::LW'(req_end_x) - cli_pkg::LW'(cx_ff);
      a_y2_in  = cli_pkg::LW'(req_end_y) - cli_pkg::LW'(cy_ff);
   end

   // Pass 1: squares, cross terms and r^2.
   cli_mul u_mul_dxdx (.clock(clock), .en(adv), .a(cli_pkg::MUL_W'(a_ff.dx)),
                       .b(cli_pkg::MUL_W'(a_ff.dx)), .p(p_dxdx));
   cli_mul u_mul_dydy (.clock(clock), .en(adv), .a(cli_pkg::MUL_W'(a_ff.dy)),
                       .b(cli_pkg::MUL_W'(a_ff.dy)), .p(p_dydy));
   cli_mul u_mul_x1y2 (.clock(clock), .en(adv), .a(cli_pkg::MUL_W'(a_ff.x1)),
                       .b(cli_pkg::MUL_W'(a_y2_ff)), .p(p_x1y2));
   cli_mul u_mul_x2y1 (.clock(clock), .en(adv), .a(cli_pkg::MUL_W'(a_x2_ff)),
                       .b(cli_pkg::MUL_W'(a_ff.y1)), .p(p_x2y1));
   cli_mul u_mul_rr (.clock(clock), .en(adv),
                     .a($signed({{(cli_pkg::MUL_W-cli_pkg::RW){1'b0}}, r_ff})),
                     .b($signed({{(cli_pkg::MUL_W-cli_pkg::RW){1'b0}}, r_ff})),
                     .p(p_rr));

   // Stage B: squared length, cross product, r^2.
   always_comb begin
      b_in     = l1_ff[cli_pkg::MUL_LAT-1];
      b_in.dr2 = p_dxdx[cli_pkg::DR_W-1:0] + p_dydy[cli_pkg::DR_W-1:0];
      b_dd_in  = $signed(p_x1y2[cli_pkg::DD_W-1:0] - p_x2y1[cli_pkg::DD_W-1:0]);
      b_rr_in  = p_rr[cli_pkg::RR_W-1:0];
   end

   // Pass 2: discriminant terms and the center part of the points.
   cli_mul u_mul_rrdr (.clock(clock), .en(adv),
                       .a($signed({{(cli_pkg::MUL_W-cli_pkg::RR_W){1'b0}}, b_rr_ff})),
                       .b($signed({{(cli_pkg::MUL_W-cli_pkg::DR_W){1'b0}}, b_ff.dr2})),
                       .p(p_rrdr));
   cli_mul u_mul_dd2 (.clock(clock), .en(adv), .a(cli_pkg::MUL_W'(b_dd_ff)),
                      .b(cli_pkg::MUL_W'(b_dd_ff)), .p(p_dd2));
   cli_mul u_mul_ax (.clock(clock), .en(adv), .a(cli_pkg::MUL_W'(b_dd_ff)),
                     .b(cli_pkg::MUL_W'(b_ff.dy)), .p(p_ax));
   cli_mul u_mul_ay (.clock(clock), .en(adv), .a(cli_pkg::MUL_W'(b_dd_ff)),
                     .b(cli_pkg::MUL_W'(b_ff.dx)), .p(p_ay));

   // Stage C: discriminant, point count and square root operand.
   always_comb begin
      delta        = $signed(p_rrdr[cli_pkg::DL_W-1:0] - p_dd2[cli_pkg::DL_W-1:0]);
      c_in.line    = l2_ff[cli_pkg::MUL_LAT-1];
      c_in.line.hit = (c_in.line.dr2 != '0) && !delta[cli_pkg::DL_W-1];
      c_in.line.two = (delta != '0);
      c_in.axis.ax = $signed(p_ax[cli_pkg::NUM_W-1:0]);
      c_in.axis.ay = -$signed(p_ay[cli_pkg::NUM_W-1:0]);
      c_rad_in     = delta[cli_pkg::DL_W-1] ? '0 : delta[cli_pkg::SQ_IN_W-1:0];
   end

   cli_sqrt u_sqrt (.clock(clock), .en(adv), .radicand(c_rad_ff), .root(root));

   // Stage D: direction terms signed by dy.
   always_comb begin
      d_sdx_in = l3_ff[cli_pkg::SQ_W-1].line.dy[cli_pkg::LW-1]
               ? -l3_ff[cli_pkg::SQ_W-1].line.dx : l3_ff[cli_pkg::SQ_W-1].line.dx;
      d_ady_in = l3_ff[cli_pkg::SQ_W-1].line.dy[cli_pkg::LW-1]
               ? -l3_ff[cli_pkg::SQ_W-1].line.dy : l3_ff[cli_pkg::SQ_W-1].line.dy;
   end

   // Pass 3: root part of the points.
   cli_mul u_mul_bx (.clock(clock), .en(adv), .a(cli_pkg::MUL_W'(d_sdx_ff)),
                     .b($signed({{(cli_pkg::MUL_W-cli_pkg::SQ_W){1'b0}}, d_root_ff})),
                     .p(p_bx));
   cli_mul u_mul_by (.clock(clock), .en(adv), .a(cli_pkg::MUL_W'(d_ady_ff)),
                     .b($signed({{(cli_pkg::MUL_W-cli_pkg::SQ_W){1'b0}}, d_root_ff})),
                     .p(p_by));

   // Stage E: plus root first, then minus root.
   always_comb begin
      bx = $signed(p_bx[cli_pkg::NUM_W-1:0]);
      by = $signed(p_by[cli_pkg::NUM_W-1:0]);
      e_n_in[0] = l4_ff[cli_pkg::MUL_LAT-1].axis.ax + bx;
      e_n_in[1] = l4_ff[cli_pkg::MUL_LAT-1].axis.ay + by;
      e_n_in[2] = l4_ff[cli_pkg::MUL_LAT-1].axis.ax - bx;
      e_n_in[3] = l4_ff[cli_pkg::MUL_LAT-1].axis.ay - by;
   end

   // Stage F: sign and magnitude for the dividers.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         neg_n[i]    = -e_n_ff[i];
         f_neg_in[i] = e_n_ff[i][cli_pkg::NUM_W-1];
         f_mag_in[i] = f_neg_in[i] ? unsigned'(neg_n[i][cli_pkg::DIVN_W-1:0])
                                   : unsigned'(e_n_ff[i][cli_pkg::DIVN_W-1:0]);
      end
   end

   genvar gi;
   for (gi = 0; gi < 4; gi++) begin : g_div
      cli_div u_div (.clock(clock), .en(adv), .num(f_mag_ff[gi]), .den(f_ff.dr2),
                     .quo(quo[gi]));
   end

   // Stage G: quotient truncated toward zero.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         g_q_in[i] = l5_ff[cli_pkg::QM_W-1].neg[i] ? -$signed({1'b0, quo[i]})
                                                  : $signed({1'b0, quo[i]});
      end
   end

   // Stage H: offset from the segment start.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         h_ex_in[i] = cli_pkg::EX_W'(g_q_ff[i])
                    - cli_pkg::EX_W'(i[0] ? g_ff.y1 : g_ff.x1);
      end
   end

   // Pass 4: projection terms.
   for (gi = 0; gi < 4; gi++) begin : g_dot
      cli_mul u_mul_dot (.clock(clock), .en(adv), .a(cli_pkg::MUL_W'(h_ex_ff[gi])),
                         .b(cli_pkg::MUL_W'(gi % 2 == 1 ? h_ff.dy : h_ff.dx)),
                         .p(p_dot[gi]));
   end

   always_comb begin
      l6_in.line = h_ff;
      for (int i = 0; i < 4; i++) begin
         l6_in.q[i] = h_q_ff[i];
      end
   end

   // Stage I: dot products and points moved back to world coordinates.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         i_dot_in[k] = $signed(p_dot[2*k][cli_pkg::DOT_W-1:0])
                     + $signed(p_dot[2*k+1][cli_pkg::DOT_W-1:0]);
      end
      for (int i = 0; i < 4; i++) begin
         i_sum_in[i] = cli_pkg::SUM_W'($signed(l6_ff[cli_pkg::MUL_LAT-1].q[i]))
                     + cli_pkg::SUM_W'(i[0] ? cy_ff : cx_ff);
      end
   end

   // Output stage: segment test and saturation.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         on_seg[k] = !i_dot_ff[k][cli_pkg::DOT_W-1]
                  && (i_dot_ff[k] <= $signed({2'b00, i_ff.dr2}));
      end
      o_keep_in[0] = i_ff.hit && (i_ff.unb || on_seg[0]);
      o_keep_in[1] = i_ff.hit && i_ff.two && (i_ff.unb || on_seg[1]);
      for (int i = 0; i < 4; i++) begin
         o_pt_in[i] = cli_pkg::sat32(i_sum_ff[i]);
      end
   end

   // Stage and delay-line payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff    <= a_in;
         a_x2_ff <= a_x2_in;
         a_y2_ff <= a_y2_in;
         l1_ff[0] <= a_ff;
         l2_ff[0] <= b_ff;
         l4_ff[0] <= d_ff;
         l6_ff[0] <= l6_in;
         for (int i = 1; i < cli_pkg::MUL_LAT; i++) begin
            l1_ff[i] <= l1_ff[i-1];
            l2_ff[i] <= l2_ff[i-1];
            l4_ff[i] <= l4_ff[i-1];
            l6_ff[i] <= l6_ff[i-1];
         end
         b_ff    <= b_in;
         b_dd_ff <= b_dd_in;
         b_rr_ff <= b_rr_in;
         c_ff     <= c_in;
         c_rad_ff <= c_rad_in;
         l3_ff[0] <= c_ff;
         for (int i = 1; i < cli_pkg::SQ_W; i++) begin
            l3_ff[i] <= l3_ff[i-1];
         end
         d_ff      <= l3_ff[cli_pkg::SQ_W-1];
         d_root_ff <= root;
         d_sdx_ff  <= d_sdx_in;
         d_ady_ff  <= d_ady_in;
         e_ff <= l4_ff[cli_pkg::MUL_LAT-1].line;
         f_ff <= e_ff;
         f_neg_ff <= f_neg_in;
         for (int i = 0; i < 4; i++) begin
            e_n_ff[i]   <= e_n_in[i];
            f_mag_ff[i] <= f_mag_in[i];
            g_q_ff[i]   <= g_q_in[i];
            h_q_ff[i]   <= g_q_ff[i];
            h_ex_ff[i]  <= h_ex_in[i];
            i_sum_ff[i] <= i_sum_in[i];
         end
         l5_ff[0].line <= f_ff;
         l5_ff[0].neg  <= f_neg_ff;
         for (int i = 1; i < cli_pkg::QM_W; i++) begin
            l5_ff[i] <= l5_ff[i-1];
         end
         g_ff <= l5_ff[cli_pkg::QM_W-1].line;
         h_ff <= g_ff;
         i_ff <= l6_ff[cli_pkg::MUL_LAT-1].line;
         for (int k = 0; k < 2; k++) begin
            i_dot_ff[k] <= i_dot_in[k];
         end
         for (int i = 0; i < 4; i++) begin
            o_pt_ff[i] <= o_pt_in[i];
         end
         o_keep_ff <= o_keep_in;
      end
   end

   // Output control: a second beat follows when both points are kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff    <= 1'b0;
         o_second_ff <= 1'b0;
      end else if (stall) begin
         o_second_ff <= 1'b1;
      end else begin
         o_vld_ff    <= i_vld_ff;
         o_second_ff <= 1'b0;
      end
   end

   // Result beat selection.
   always_comb begin
      rsp_valid   = o_vld_ff;
      rsp_point_x = '0;
      rsp_point_y = '0;
      rsp_found   = 1'b0;
      rsp_last    = 1'b1;
      if (o_second_ff) begin
         rsp_point_x = o_pt_ff[2];
         rsp_point_y = o_pt_ff[3];
         rsp_found   = 1'b1;
      end else if (o_keep_ff[0]) begin
         rsp_point_x = o_pt_ff[0];
         rsp_point_y = o_pt_ff[1];
         rsp_found   = 1'b1;
         rsp_last    = !o_keep_ff[1];
      end else if (o_keep_ff[1]) begin
         rsp_point_x = o_pt_ff[2];
         rsp_point_y = o_pt_ff[3];
         rsp_found   = 1'b1;
      end
   end

endmodule

FILE: hw/rtl/cli_mul.sv
// Pipelined signed 68 x 68 multiplier built from 23 x 23 limb products.
// Uses cli_pkg for widths and latency.
module cli_mul (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [cli_pkg::MUL_W-1:0]    a,
   input  logic signed [cli_pkg::MUL_W-1:0]    b,
   output logic signed [cli_pkg::PROD_W-1:0]   p
);

   logic [cli_pkg::MUL_W-1:0]               am_ff, bm_ff;
   logic [cli_pkg::MUL_LAT-2:0]             neg_ff;
   logic [cli_pkg::NLIMB*cli_pkg::LIMB_W-1:0] ae, be;
   logic [cli_pkg::PP_W-1:0]                pp_ff [cli_pkg::NLIMB*cli_pkg::NLIMB];
   logic [cli_pkg::ROW_W-1:0]               row_in [cli_pkg::NLIMB];
   logic [cli_pkg::ROW_W-1:0]               row_ff [cli_pkg::NLIMB];
   logic [cli_pkg::PROD_W-1:0]              mag_in, mag_ff;
   logic signed [cli_pkg::PROD_W-1:0]       p_ff;

   assign ae = (cli_pkg::NLIMB*cli_pkg::LIMB_W)'(am_ff);
   assign be = (cli_pkg::NLIMB*cli_pkg::LIMB_W)'(bm_ff);

   // Row sums of the limb products, then the total magnitude.
   always_comb begin
      for (int i = 0; i < cli_pkg::NLIMB; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < cli_pkg::NLIMB; j++) begin
            row_in[i] = row_in[i] + (cli_pkg::ROW_W'(pp_ff[i*cli_pkg::NLIMB+j])
                                     << (cli_pkg::LIMB_W * j));
         end
      end
      mag_in = '0;
      for (int i = 0; i < cli_pkg::NLIMB; i++) begin
         mag_in = mag_in + (cli_pkg::PROD_W'(row_ff[i]) << (cli_pkg::LIMB_W * i));
      end
   end

   // Magnitudes, limb products, rows, total and sign fix, one stage each.
   always_ff @(posedge clock) begin
      if (en) begin
         am_ff  <= a[cli_pkg::MUL_W-1] ? unsigned'(-a) : unsigned'(a);
         bm_ff  <= b[cli_pkg::MUL_W-1] ? unsigned'(-b) : unsigned'(b);
         neg_ff <= {neg_ff[cli_pkg::MUL_LAT-3:0], a[cli_pkg::MUL_W-1] ^ b[cli_pkg::MUL_W-1]};
         for (int i = 0; i < cli_pkg::NLIMB; i++) begin
            for (int j = 0; j < cli_pkg::NLIMB; j++) begin
               pp_ff[i*cli_pkg::NLIMB+j] <= ae[i*cli_pkg::LIMB_W +: cli_pkg::LIMB_W]
                                          * be[j*cli_pkg::LIMB_W +: cli_pkg::LIMB_W];
            end
         end
         for (int i = 0; i < cli_pkg::NLIMB; i++) begin
            row_ff[i] <= row_in[i];
         end
         mag_ff <= mag_in;
         p_ff   <= neg_ff[cli_pkg::MUL_LAT-2] ? -$signed(mag_ff) : $signed(mag_ff);
      end
   end

   assign p = p_ff;

endmodule

FILE: hw/rtl/cli_sqrt.sv
// Pipelined floor square root, one root bit per stage.
// Uses cli_pkg for widths.
module cli_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [cli_pkg::SQ_IN_W-1:0]   radicand,
   output logic [cli_pkg::SQ_W-1:0]      root
);

   logic [cli_pkg::REM_W-1:0] rem_ff  [cli_pkg::SQ_W];
   logic [cli_pkg::SQ_W-1:0]  root_ff [cli_pkg::SQ_W];

   genvar k;
   for (k = 0; k < cli_pkg::SQ_W; k++) begin : g_step
      localparam int B = cli_pkg::SQ_W - 1 - k;
      logic [cli_pkg::REM_W-1:0] rem_prev;
      logic [cli_pkg::REM_W-1:0] trial;
      logic [cli_pkg::SQ_W-1:0]  root_prev;

      if (k == 0) begin : g_first
         assign rem_prev  = cli_pkg::REM_W'(radicand);
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // Setting bit B of the root adds 2*root*2^B + 2^(2B) to its square.
      assign trial = (cli_pkg::REM_W'(root_prev) << (B + 1))
                   | (cli_pkg::REM_W'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_prev >= trial) begin
               rem_ff[k]  <= rem_prev - trial;
               root_ff[k] <= root_prev | (cli_pkg::SQ_W'(1) << B);
            end else begin
               rem_ff[k]  <= rem_prev;
               root_ff[k] <= root_prev;
            end
         end
      end
   end

   assign root = root_ff[cli_pkg::SQ_W-1];

endmodule

FILE: hw/rtl/cli_div.sv
// Pipelined restoring divider, one quotient bit per stage, magnitudes only.
// Uses cli_pkg for widths.
module cli_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [cli_pkg::DIVN_W-1:0]    num,
   input  logic [cli_pkg::DR_W-1:0]      den,
   output logic [cli_pkg::QM_W-1:0]      quo
);

   logic [cli_pkg::DIVN_W-1:0] rem_ff [cli_pkg::QM_W];
   logic [cli_pkg::DR_W-1:0]   den_ff [cli_pkg::QM_W];
   logic [cli_pkg::QM_W-1:0]   quo_ff [cli_pkg::QM_W];

   genvar k;
   for (k = 0; k < cli_pkg::QM_W; k++) begin : g_step
      localparam int B = cli_pkg::QM_W - 1 - k;
      logic [cli_pkg::DIVN_W-1:0] rem_prev;
      logic [cli_pkg::DIVN_W-1:0] shifted;
      logic [cli_pkg::DR_W-1:0]   den_prev;
      logic [cli_pkg::QM_W-1:0]   quo_prev;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign shifted = cli_pkg::DIVN_W'(den_prev) << B;

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k] <= den_prev;
            if (rem_prev >= shifted) begin
               rem_ff[k] <= rem_prev - shifted;
               quo_ff[k] <= quo_prev | (cli_pkg::QM_W'(1) << B);
            end else begin
               rem_ff[k] <= rem_prev;
               quo_ff[k] <= quo_prev;
            end
         end
      end
   end

   assign quo = quo_ff[cli_pkg::QM_W-1];

endmodule

FILE: sim/circle_line_intersection_tb.sv
// Self-checking testbench for the circle/line intersection block.
// Needs cli_pkg and the circle_line_intersection RTL; reads nothing else.
module circle_line_intersection_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [199:0] wide_type;

   typedef struct packed {
      logic signed [cli_pkg::CW-1:0] x;
      logic signed [cli_pkg::CW-1:0] y;
      logic                          found;
      logic                          last;
   } point_type;

   // Predicts the points of every accepted line and checks the result beats.
   class intersect_scoreboard_type;
      logic signed [cli_pkg::CW-1:0] cx;
      logic signed [cli_pkg::CW-1:0] cy;
      logic [cli_pkg::RW-1:0]        radius;
      point_type                     expected_points[$];
      int                            errors;
      int                            lines;
      int                            hits;
      int                            misses;

      function new();
         cx = '0;
         cy = '0;
         radius = '0;
         errors = 0;
         lines = 0;
         hits = 0;
         misses = 0;
      endfunction

      function wide_type floor_sqrt(wide_type a);
         wide_type res;
         wide_type t;
         res = '0;
         for (int b = 95; b >= 0; b--) begin
            t = res;
            t[b] = 1'b1;
            if (t * t <= a) res = t;
         end
         return res;
      endfunction

      function logic signed [cli_pkg::CW-1:0] clamp32(wide_type v);
         if (v >= wide_type'(64'sd2147483647)) return 32'h7FFF_FFFF;
         if (v <= -wide_type'(64'sd2147483648)) return 32'h8000_0000;
         return v[cli_pkg::CW-1:0];
      endfunction

      // Works out the points of one line beat in circle-local coordinates.
      function void note_line(logic signed [cli_pkg::CW-1:0] sx,
                              logic signed [cli_pkg::CW-1:0] sy,
                              logic signed [cli_pkg::CW-1:0] ex,
                              logic signed [cli_pkg::CW-1:0] ey,
                              logic ub);
         wide_type x1, y1, x2, y2, dx, dy, dr2, dd, rr, delta, sq;
         wide_type ax, ay, bx, by, qx, qy, dot;
         point_type p;
         int npts;
         int kept;
         logic keep;
         x1 = wide_type'(sx) - wide_type'(cx);
         y1 = wide_type'(sy) - wide_type'(cy);
         x2 = wide_type'(ex) - wide_type'(cx);
         y2 = wide_type'(ey) - wide_type'(cy);
         dx = wide_type'(ex) - wide_type'(sx);
         dy = wide_type'(ey) - wide_type'(sy);
         dr2 = dx * dx + dy * dy;
         dd = x1 * y2 - x2 * y1;
         rr = wide_type'({1'b0, radius});
         delta = rr * rr * dr2 - dd * dd;
         kept = 0;
         lines++;
         if (dr2 != 0 && delta >= 0) begin
            sq = floor_sqrt(delta);
            ax = dd * dy;
            ay = -(dd * dx);
            bx = (dy < 0 ? -dx : dx) * sq;
            by = (dy < 0 ? -dy : dy) * sq;
            npts = (delta == 0) ? 1 : 2;
            for (int k = 0; k < npts; k++) begin
               qx = (k == 0 ? ax + bx : ax - bx) / dr2;
               qy = (k == 0 ? ay + by : ay - by) / dr2;
               keep = 1'b1;
               if (!ub) begin
                  dot = (qx - x1) * dx + (qy - y1) * dy;
                  keep = (dot >= 0) && (dot <= dr2);
               end
               if (keep) begin
                  p.x = clamp32(qx + wide_type'(cx));
                  p.y = clamp32(qy + wide_type'(cy));
                  p.found = 1'b1;
                  p.last = 1'b0;
                  expected_points = {expected_points, p};
                  kept++;
               end
            end
         end
         if (kept == 0) begin
            p = '{x: '0, y: '0, found: 1'b0, last: 1'b1};
            expected_points = {expected_points, p};
            misses++;
         end else begin
            expected_points[$].last = 1'b1;
            hits += kept;
         end
      endfunction

      // Compares one result beat with the oldest expected point.
      function void check_result(point_type got);
         point_type want;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result beat x=%h y=%h found=%b last=%b",
                     $time, got.x, got.y, got.found, got.last);
            errors++;
            return;
         end
         want = expected_points.pop_front();
         if (got.x !== want.x) begin
            $display("%0t: point_x expected %h actual %h", $time, want.x, got.x);
            errors++;
         end
         if (got.y !== want.y) begin
            $display("%0t: point_y expected %h actual %h", $time, want.y, got.y);
            errors++;
         end
         if (got.found !== want.found) begin
            $display("%0t: found expected %b actual %b", $time, want.found, got.found);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 150;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [cli_pkg::CW-1:0] req_start_x, req_start_y, req_end_x, req_end_y;
   logic req_unbounded_line;
   logic rsp_valid;
   logic signed [cli_pkg::CW-1:0] rsp_point_x, rsp_point_y;
   logic rsp_found, rsp_last;
   logic csr_write;
   logic [cli_pkg::CSR_IW-1:0] csr_index;
   logic [cli_pkg::CW-1:0] csr_data;

   intersect_scoreboard_type board = new();
   int idle_cycles;
   bit gaps_on;

   circle_line_intersection DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor: note accepted lines, check result beats, and watch for a hang.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy) begin
            board.note_line(req_start_x, req_start_y, req_end_x, req_end_y,
                            req_unbounded_line);
         end
         if (rsp_valid) begin
            board.check_result('{x: rsp_point_x, y: rsp_point_y,
                                 found: rsp_found, last: rsp_last});
         end
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Sends one line beat and returns once it has been accepted.
   task automatic send_line(logic signed [cli_pkg::CW-1:0] sx,
                            logic signed [cli_pkg::CW-1:0] sy,
                            logic signed [cli_pkg::CW-1:0] ex,
                            logic signed [cli_pkg::CW-1:0] ey,
                            logic ub);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      req_unbounded_line <= ub;
      // busy only changes at a rising edge, so its value at the falling edge holds.
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
   endtask

   // Waits until every expected point has arrived and the pipeline is empty.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write beat; the caller drops csr_write after the last one.
   task automatic write_reg(logic [cli_pkg::CSR_IW-1:0] idx, logic [cli_pkg::CW-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      if (idx == cli_pkg::CSR_CENTER_X) board.cx = value;
      else if (idx == cli_pkg::CSR_CENTER_Y) board.cy = value;
      else board.radius = value[cli_pkg::RW-1:0];
   endtask

   task automatic set_circle(logic signed [cli_pkg::CW-1:0] x,
                             logic signed [cli_pkg::CW-1:0] y,
                             logic [cli_pkg::RW-1:0] r);
      write_reg(cli_pkg::CSR_CENTER_X, x);
      write_reg(cli_pkg::CSR_CENTER_Y, y);
      write_reg(cli_pkg::CSR_RADIUS, {1'b0, r});
      csr_write <= 1'b0;
   endtask

   // A coordinate within a random power-of-two span around a base value.
   function automatic logic signed [cli_pkg::CW-1:0] near(logic signed [cli_pkg::CW-1:0] base);
      int k;
      logic [cli_pkg::CW-1:0] off;
      k = $urandom_range(4, 31);
      off = $urandom() & ((32'd1 << k) - 1);
      return base + off - (32'd1 << (k - 1));
   endfunction

   // One random line: mostly near the circle, some fully random, some special shapes.
   task automatic random_line();
      logic signed [cli_pkg::CW-1:0] sx, sy, ex, ey;
      logic signed [cli_pkg::CW-1:0] r;
      int kind;
      kind = $urandom_range(0, 9);
      r = {1'b0, board.radius};
      sx = near(board.cx);
      sy = near(board.cy);
      ex = near(board.cx);
      ey = near(board.cy);
      case (kind)
         0: begin
            sx = $urandom();
            sy = $urandom();
            ex = $urandom();
            ey = $urandom();
         end
         1: begin
            ex = sx;
            ey = sy;
         end
         2: begin
            // Horizontal line tangent to the top or bottom of the circle.
            sy = $urandom_range(0, 1) ? board.cy + r : board.cy - r;
            ey = sy;
         end
         3: begin
            // Vertical tangent line.
            sx = $urandom_range(0, 1) ? board.cx + r : board.cx - r;
            ex = sx;
         end
         4: begin
            // Segment starting near the circle center.
            sx = board.cx + ($urandom() & 32'hFFFF) - 32'h8000;
            sy = board.cy + ($urandom() & 32'hFFFF) - 32'h8000;
         end
         default: begin
         end
      endcase
      send_line(sx, sy, ex, ey, 1'($urandom_range(0, 1)));
   endtask

   // Directed lines for the circle at the origin with radius one.
   task automatic directed_lines();
      localparam logic signed [cli_pkg::CW-1:0] ONE = 32'sh0001_0000;
      localparam logic signed [cli_pkg::CW-1:0] MAXV = 32'sh7FFF_FFFF;
      localparam logic signed [cli_pkg::CW-1:0] MINV = 32'sh8000_0000;
      send_line(-2 * ONE, 0, 2 * ONE, 0, 1'b0);       // secant, both kept
      send_line(-2 * ONE, 0, 2 * ONE, 0, 1'b1);
      send_line(-ONE / 4, 0, ONE / 4, 0, 1'b0);      // segment inside, no point
      send_line(-ONE / 4, 0, ONE / 4, 0, 1'b1);      // same line unbounded
      send_line(0, 0, 2 * ONE, 0, 1'b0);             // one end inside
      send_line(-2 * ONE, ONE, 2 * ONE, ONE, 1'b0);  // tangent
      send_line(ONE, -3 * ONE, ONE, 3 * ONE, 1'b1);  // vertical tangent
      send_line(-2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE, 1'b1); // misses
      send_line(ONE / 2, ONE / 3, ONE / 2, ONE / 3, 1'b1);  // degenerate
      send_line(2 * ONE, 2 * ONE, -2 * ONE, -2 * ONE, 1'b0); // falling diagonal
      send_line(-2 * ONE, 3 * ONE, 2 * ONE, -ONE, 1'b0);
      send_line(MINV, MINV, MAXV, MAXV, 1'b0);
      send_line(MAXV, MINV, MINV, MAXV, 1'b1);
      send_line(MINV, 0, MAXV, 0, 1'b0);
      send_line(0, MAXV, 0, MINV, 1'b0);
      send_line(MAXV, MAXV, MAXV, MAXV, 1'b1);
      send_line(MINV, MINV, MAXV, MINV, 1'b1);
   endtask

   initial begin
      int phase_items;
      reset = 1'b1;
      start = 1'b0;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x = '0;
      req_end_y = '0;
      req_unbounded_line = 1'b0;
      csr_write = 1'b0;
      csr_index = cli_pkg::CSR_CENTER_X;
      csr_data = '0;
      gaps_on = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset circle: zero radius at the origin.
      send_line(-32'sh1_0000, 0, 32'sh1_0000, 0, 1'b1);
      send_line(0, 0, 32'sh1_0000, 0, 1'b0);
      drain();

      set_circle(0, 0, 31'h1_0000);
      directed_lines();
      drain();

      // Random phases over a range of circles, extremes included.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_circle(32'sh0003_8000, -32'sh0001_2000, 31'h0004_0000);
            1: set_circle(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
            2: set_circle(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
            3: set_circle(0, 0, 31'h0000_0000);
            4: set_circle(0, 0, 31'h0000_0001);
            5: set_circle(32'sh7FFF_0000, 32'sh8000_FFFF, 31'h0100_0000);
            default: set_circle($urandom(), $urandom(), cli_pkg::RW'($urandom()));
         endcase
         phase_items = (phase == 7) ? 460 : 200;
         for (int n = 0; n < phase_items; n++) begin
            if (phase == 7 && n == 160) gaps_on = 1'b0;
            if (phase == 2 && n == 100) begin
               // Hold off until the block has returned every point.
               start <= 1'b0;
               @(posedge clock);
               while (board.expected_points.size() != 0) @(posedge clock);
            end
            random_line();
         end
         drain();
      end

      $display("Covered %0d lines giving %0d intersection points and %0d empty results,",
               board.lines, board.hits, board.misses);
      $display("over ten circle settings including saturating centers and zero radius.");
      if (board.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/cli_pkg.sv
hw/rtl/cli_mul.sv
hw/rtl/cli_sqrt.sv
hw/rtl/cli_div.sv
hw/rtl/circle_line_intersection.sv
sim/circle_line_intersection_tb.sv
